[sv/srcg_pkg.sv]
// Shared constants and types for the sync raster candidate generator.
`timescale 1ns / 1ps
package srcg_pkg;

	localparam int unsigned MAX_RESULTS = 64;
	localparam int unsigned IDX_W       = 15;
	localparam int unsigned HZ_W        = 35;
	localparam int unsigned SPAN_W      = 32;
	localparam int unsigned OFF_W       = 33;
	localparam int unsigned LIM_W       = 7;

	localparam logic [IDX_W-1:0]  LOW_COUNT = 15'd7497;
	localparam logic [IDX_W-1:0]  ALL_COUNT = 15'd22254;
	localparam logic [LIM_W-1:0]  LIMIT_RST = 7'd16;
	localparam logic [LIM_W-1:0]  LIMIT_MAX = LIM_W'(MAX_RESULTS);

	// floor(x/3) = (x * RECIP3) >> 16 for x below LOW_COUNT
	localparam logic [14:0] RECIP3     = 15'd21846;
	localparam logic [20:0] LOW_STEP   = 21'd1200000;
	localparam logic [20:0] HIGH_STEP  = 21'd1440000;
	localparam logic [HZ_W-1:0] HIGH_BASE = 35'd3000000000;

	typedef struct packed {
		logic            start;
		logic [IDX_W-1:0] idx;
	} srcg_pt_req_t;

	typedef struct packed {
		logic            done;
		logic [HZ_W-1:0] hz;
	} srcg_pt_rsp_t;

	function automatic logic [HZ_W-1:0] m_offset(input logic [1:0] r);
		case (r)
			2'd0:    m_offset = 35'd50000;
			2'd1:    m_offset = 35'd150000;
			2'd2:    m_offset = 35'd250000;
			default: m_offset = 35'd50000;
		endcase
	endfunction

endpackage

[sv/srcg_point.sv]
// Shared raster point unit: index to frequency in hertz, two register stages.
`timescale 1ns / 1ps
module srcg_point
	import srcg_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  srcg_pt_req_t req,
	output srcg_pt_rsp_t rsp
);

	logic             v_s1, v_s2;
	logic             low_s1;
	logic [12:0]      idx_s1;
	logic [11:0]      q_s1;
	logic [13:0]      d_s1;
	logic [HZ_W-1:0]  hz_s2;

	logic [27:0]      recip_prod;
	logic [12:0]      rem13;
	logic [13:0]      mul_a;
	logic [20:0]      mul_b;
	logic [HZ_W-1:0]  add_c;
	logic [HZ_W-1:0]  prod;
	logic [IDX_W-1:0] d_full;

	assign recip_prod = 28'(req.idx[12:0]) * 28'(RECIP3);
	assign d_full     = req.idx - LOW_COUNT;

	assign rem13 = idx_s1 - 13'(q_s1) * 13'd3;
	assign mul_a = low_s1 ? {2'b00, q_s1 + 12'd1} : d_s1;
	assign mul_b = low_s1 ? LOW_STEP : HIGH_STEP;
	assign add_c = low_s1 ? m_offset(rem13[1:0]) : HIGH_BASE;
	assign prod  = 35'(mul_a) * 35'(mul_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		low_s1 <= req.idx < LOW_COUNT;
		idx_s1 <= req.idx[12:0];
		q_s1   <= recip_prod[27:16];
		d_s1   <= d_full[13:0];
		hz_s2  <= prod + add_c;
	end

	assign rsp.done = v_s2;
	assign rsp.hz   = hz_s2;

endmodule

[sv/sync_raster_candidate_generator.sv]
// Top level: query sequencer, outward walk and result register.
//
//  channel  | dir | handshake               | payload
//  s_axis   | in  | s_axis_tvalid/tready    | tdata: center_hz, half_width_hz
//  m_axis   | out | m_axis_tvalid/tready    | tdata: raster_hz, offset_hz; tuser found; tlast
//  cfg      | in  | cfg_we                  | cfg_wdata: result_limit
//
// A query takes an accept step, a binary search of at most 15 probes, each
// through the shared point unit, plus a closing step, a fetch of both
// neighbours, then per candidate a decide step plus a point fetch while that
// side still has points, and a closing decide step and final step.
// Reset clears the sequencer and sets result_limit to 16; no clearing pass.
// A stalled m_axis holds the walk; the next query is taken once the final
// result sits in the output register.
`timescale 1ns / 1ps
module sync_raster_candidate_generator
	import srcg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [71:0]      s_axis_tdata,   // [34:0] center_hz, [66:35] half_width_hz
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [71:0]      m_axis_tdata,   // [34:0] raster_hz, [67:35] offset_hz
	output logic             m_axis_tuser,   // [0] found
	output logic             m_axis_tlast,
	input  logic             cfg_we,
	input  logic [LIM_W-1:0] cfg_wdata
);

	typedef enum logic [3:0] {
		S_IDLE, S_BS, S_BS_WAIT, S_FL, S_FL_WAIT, S_FR, S_FR_WAIT, S_DECIDE, S_FINAL
	} state_t;

	state_t            state_q;
	logic [LIM_W-1:0]  cfg_limit_q, limit_q, count_q;
	logic [HZ_W-1:0]   center_q;
	logic [SPAN_W-1:0] half_q;
	logic [IDX_W-1:0]  lo_q, hi_q, mid_q, left_q, right_q;
	logic              has_left_q, both_q, lok_q, rok_q;
	logic [HZ_W-1:0]   dl_q, dr_q;
	logic [HZ_W-1:0]   pend_hz_q;
	logic [OFF_W-1:0]  pend_off_q;
	logic              m_valid_q, m_found_q, m_last_q;
	logic [HZ_W-1:0]   m_hz_q;
	logic [OFF_W-1:0]  m_off_q;

	srcg_pt_req_t      pt_req;
	srcg_pt_rsp_t      pt_rsp;
	logic [IDX_W-1:0]  mid_c;
	logic [HZ_W-1:0]   in_center;
	logic [SPAN_W-1:0] in_half;
	logic [LIM_W-1:0]  lim_c;
	logic [HZ_W-1:0]   d_below, d_above;
	logic              out_free, take_l, take_r, in_acc, load_out;

	srcg_point u_point (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (pt_req),
		.rsp    (pt_rsp)
	);

	assign in_center = s_axis_tdata[34:0];
	assign in_half   = s_axis_tdata[66:35];
	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign lim_c     = (cfg_limit_q == '0) ? 7'd1 :
	                   (cfg_limit_q > LIMIT_MAX) ? LIMIT_MAX : cfg_limit_q;
	assign mid_c     = lo_q + ((hi_q - lo_q) >> 1);
	assign d_below   = center_q - pt_rsp.hz;
	assign d_above   = pt_rsp.hz - center_q;
	assign out_free  = !m_valid_q || m_axis_tready;
	assign take_l    = lok_q && (!rok_q || dl_q <= dr_q);
	assign take_r    = !take_l && rok_q;
	assign load_out  = out_free && ((state_q == S_FINAL) ||
	                   (state_q == S_DECIDE && count_q != '0 && count_q != limit_q &&
	                    (lok_q || rok_q)));

	always_comb begin
		pt_req.start = 1'b0;
		pt_req.idx   = mid_c;
		case (state_q)
			S_BS: begin
				pt_req.start = lo_q < hi_q;
				pt_req.idx   = mid_c;
			end
			S_FL: begin
				pt_req.start = has_left_q;
				pt_req.idx   = left_q;
			end
			S_FR: begin
				pt_req.start = right_q < ALL_COUNT;
				pt_req.idx   = right_q;
			end
			default: begin
				pt_req.start = 1'b0;
				pt_req.idx   = mid_c;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cfg_limit_q <= LIMIT_RST;
			limit_q     <= LIMIT_RST;
			count_q     <= '0;
			m_valid_q   <= 1'b0;
			has_left_q  <= 1'b0;
			both_q      <= 1'b0;
			lok_q       <= 1'b0;
			rok_q       <= 1'b0;
		end else begin
			if (cfg_we)
				cfg_limit_q <= cfg_wdata;
			if (m_valid_q && m_axis_tready && !load_out)
				m_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						center_q <= in_center;
						half_q   <= in_half;
						limit_q  <= lim_c;
						count_q  <= '0;
						lo_q     <= '0;
						hi_q     <= ALL_COUNT;
						state_q  <= (in_half == '0) ? S_FINAL : S_BS;
					end
				end
				S_BS: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid_c;
						state_q <= S_BS_WAIT;
					end else begin
						right_q    <= lo_q;
						has_left_q <= lo_q != '0;
						left_q     <= lo_q - 15'd1;
						both_q     <= 1'b1;
						state_q    <= S_FL;
					end
				end
				S_BS_WAIT: begin
					if (pt_rsp.done) begin
						if (pt_rsp.hz < center_q)
							lo_q <= mid_q + 15'd1;
						else
							hi_q <= mid_q;
						state_q <= S_BS;
					end
				end
				S_FL: begin
					if (has_left_q) begin
						state_q <= S_FL_WAIT;
					end else begin
						lok_q   <= 1'b0;
						state_q <= both_q ? S_FR : S_DECIDE;
					end
				end
				S_FL_WAIT: begin
					if (pt_rsp.done) begin
						dl_q    <= d_below;
						lok_q   <= d_below <= {3'b000, half_q};
						state_q <= both_q ? S_FR : S_DECIDE;
					end
				end
				S_FR: begin
					both_q <= 1'b0;
					if (right_q < ALL_COUNT) begin
						state_q <= S_FR_WAIT;
					end else begin
						rok_q   <= 1'b0;
						state_q <= S_DECIDE;
					end
				end
				S_FR_WAIT: begin
					if (pt_rsp.done) begin
						dr_q    <= d_above;
						rok_q   <= d_above <= {3'b000, half_q};
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (count_q == limit_q || !(lok_q || rok_q)) begin
						state_q <= S_FINAL;
					end else if (count_q == '0 || out_free) begin
						if (count_q != '0) begin
							m_valid_q <= 1'b1;
							m_hz_q    <= pend_hz_q;
							m_off_q   <= pend_off_q;
							m_found_q <= 1'b1;
							m_last_q  <= 1'b0;
						end
						count_q <= count_q + 7'd1;
						if (take_l) begin
							pend_hz_q  <= center_q - dl_q;
							pend_off_q <= 33'd0 - dl_q[32:0];
							if (left_q == '0)
								has_left_q <= 1'b0;
							else
								left_q <= left_q - 15'd1;
							state_q <= S_FL;
						end else if (take_r) begin
							pend_hz_q  <= center_q + dr_q;
							pend_off_q <= dr_q[32:0];
							right_q    <= right_q + 15'd1;
							state_q    <= S_FR;
						end
					end
				end
				S_FINAL: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_last_q  <= 1'b1;
						if (count_q != '0) begin
							m_hz_q    <= pend_hz_q;
							m_off_q   <= pend_off_q;
							m_found_q <= 1'b1;
						end else begin
							m_hz_q    <= '0;
							m_off_q   <= '0;
							m_found_q <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = state_q == S_IDLE;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {4'b0000, m_off_q, m_hz_q};
	assign m_axis_tuser  = m_found_q;
	assign m_axis_tlast  = m_last_q;

	a_pt_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		pt_rsp.done |-> (state_q == S_BS_WAIT || state_q == S_FL_WAIT ||
		                 state_q == S_FR_WAIT))
		else $error("point unit answered outside a wait state");

	a_count_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> count_q <= limit_q)
		else $error("candidate count beyond limit");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_found_q) |-> m_last_q)
		else $error("empty result without last mark");

	a_idle_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINAL && out_free) |=> (state_q == S_IDLE && m_valid_q && m_last_q))
		else $error("final result not loaded");

endmodule
